/* design/url_ss_pkg.sv */
// url_ss_pkg: shared types, codes and helper functions for the url stream splitter
// used by url_ss_classify, url_ss_queue and url_stream_splitter_top; no dependencies
package url_ss_pkg;

  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_SCHEME  = 3'd0,
    PH_HOST    = 3'd1,
    PH_PORT    = 3'd2,
    PH_PATH    = 3'd3,
    PH_QUERY   = 3'd4,
    PH_FRAG    = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  localparam logic [3:0] SEG_SCHEME  = 4'd0;
  localparam logic [3:0] SEG_SEP     = 4'd1;
  localparam logic [3:0] SEG_HOST    = 4'd2;
  localparam logic [3:0] SEG_COLON   = 4'd3;
  localparam logic [3:0] SEG_PORT    = 4'd4;
  localparam logic [3:0] SEG_PATH    = 4'd5;
  localparam logic [3:0] SEG_QMARK   = 4'd6;
  localparam logic [3:0] SEG_QUERY   = 4'd7;
  localparam logic [3:0] SEG_HASH    = 4'd8;
  localparam logic [3:0] SEG_FRAG    = 4'd9;
  localparam logic [3:0] SEG_DISCARD = 4'd10;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_NO_SEP = 3'd1;
  localparam logic [2:0] ERR_HOST   = 3'd2;
  localparam logic [2:0] ERR_DIGIT  = 3'd3;
  localparam logic [2:0] ERR_RANGE  = 3'd4;

  localparam logic [2:0] MATCH_FULL = 3'd4;
  localparam logic [2:0] MATCH_FAIL = 3'd5;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_P     = 8'h70;

  localparam logic [19:0] PORT_MAX         = 20'd65535;
  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  held;
    logic [2:0]  sm;
    logic [15:0] port_acc;
    logic [2:0]  err;
    logic        host_started;
    logic        path_seen;
  } parse_state_t;

  localparam parse_state_t STATE_RST = '{PH_SCHEME, 2'd0, 3'd0, 16'd0, ERR_NONE, 1'b0, 1'b0};

  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  segment;
    logic        run_last;
    logic        done_res;
    logic [2:0]  error_code;
    logic [15:0] port_value;
    logic        path_defaulted;
  } result_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] data;
    logic [MAX_RES-1:0][3:0] seg;
    logic [1:0]              cnt;
  } emit_list_t;

  function automatic logic [7:0] http_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = CH_H;
      2'd1: c = CH_T;
      2'd2: c = CH_T;
      2'd3: c = CH_P;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] sm_step(input logic [2:0] sm, input logic [7:0] b);
    logic [2:0] r;
    if (sm < MATCH_FULL && b == http_char(sm[1:0])) begin
      r = sm + 3'd1;
    end else begin
      r = MATCH_FAIL;
    end
    return r;
  endfunction

  function automatic emit_list_t push_res(input emit_list_t l, input logic [7:0] b,
                                          input logic [3:0] s);
    emit_list_t r;
    r = l;
    if (l.cnt < 2'd3) begin
      r.data[l.cnt] = b;
      r.seg[l.cnt]  = s;
      r.cnt         = l.cnt + 2'd1;
    end
    return r;
  endfunction

endpackage

/* design/url_ss_classify.sv */
// url_ss_classify: per-byte parse step, next parse state and up to three results
// depends on url_ss_pkg
module url_ss_classify (
  input  url_ss_pkg::parse_state_t           st,
  input  logic [7:0]                         data_byte,
  input  logic                               last_byte,
  input  logic [15:0]                        default_port,
  output url_ss_pkg::parse_state_t           st_next,
  output url_ss_pkg::result_t [url_ss_pkg::MAX_RES-1:0] res,
  output logic [1:0]                         res_cnt
);

  logic        is_colon;
  logic        is_slash;
  logic        is_quest;
  logic        is_hash;
  logic        is_digit;
  logic [7:0]  digit_raw;
  logic [19:0] port_try;
  logic        port_bad;

  url_ss_pkg::parse_state_t st_mid;
  url_ss_pkg::parse_state_t st_post;
  url_ss_pkg::emit_list_t   lst;

  assign is_colon  = data_byte == url_ss_pkg::CH_COLON;
  assign is_slash  = data_byte == url_ss_pkg::CH_SLASH;
  assign is_quest  = data_byte == url_ss_pkg::CH_QUEST;
  assign is_hash   = data_byte == url_ss_pkg::CH_HASH;
  assign is_digit  = data_byte >= url_ss_pkg::CH_ZERO && data_byte <= url_ss_pkg::CH_NINE;
  assign digit_raw = data_byte - url_ss_pkg::CH_ZERO;
  assign port_try  = ({4'd0, st.port_acc} << 3) + ({4'd0, st.port_acc} << 1)
                   + {16'd0, digit_raw[3:0]};
  assign port_bad  = port_try > url_ss_pkg::PORT_MAX || port_try == 20'd0;

  // next parse state
  always_comb begin
    logic taken;
    taken  = 1'b0;
    st_mid = st;
    unique case (st.phase)
      url_ss_pkg::PH_SCHEME: begin
        if (st.held == 2'd2) begin
          if (is_slash) begin
            st_mid.held  = 2'd0;
            st_mid.phase = url_ss_pkg::PH_HOST;
            taken        = 1'b1;
          end else begin
            st_mid.sm   = url_ss_pkg::sm_step(
                            url_ss_pkg::sm_step(st_mid.sm, url_ss_pkg::CH_COLON),
                            url_ss_pkg::CH_SLASH);
            st_mid.held = 2'd0;
          end
        end else if (st.held == 2'd1) begin
          if (is_slash) begin
            st_mid.held = 2'd2;
            taken       = 1'b1;
          end else begin
            st_mid.sm   = url_ss_pkg::sm_step(st_mid.sm, url_ss_pkg::CH_COLON);
            st_mid.held = 2'd0;
          end
        end
        if (!taken) begin
          if (is_colon) begin
            st_mid.held = 2'd1;
          end else begin
            st_mid.sm = url_ss_pkg::sm_step(st_mid.sm, data_byte);
          end
        end
      end
      url_ss_pkg::PH_HOST: begin
        if (is_colon || is_slash || is_quest || is_hash) begin
          priority if (!st.host_started) begin
            if (st.err == url_ss_pkg::ERR_NONE) st_mid.err = url_ss_pkg::ERR_HOST;
            st_mid.phase = url_ss_pkg::PH_DISCARD;
          end else if (is_colon) begin
            st_mid.phase = url_ss_pkg::PH_PORT;
          end else if (is_slash) begin
            st_mid.path_seen = 1'b1;
            st_mid.phase     = url_ss_pkg::PH_PATH;
          end else if (is_quest) begin
            st_mid.phase = url_ss_pkg::PH_QUERY;
          end else begin
            st_mid.phase = url_ss_pkg::PH_FRAG;
          end
        end else begin
          st_mid.host_started = 1'b1;
        end
      end
      url_ss_pkg::PH_PORT: begin
        priority if (is_slash) begin
          st_mid.path_seen = 1'b1;
          st_mid.phase     = url_ss_pkg::PH_PATH;
        end else if (is_quest) begin
          st_mid.phase = url_ss_pkg::PH_QUERY;
        end else if (is_hash) begin
          st_mid.phase = url_ss_pkg::PH_FRAG;
        end else if (is_digit && !port_bad) begin
          st_mid.port_acc = port_try[15:0];
        end else begin
          if (st.err == url_ss_pkg::ERR_NONE) begin
            st_mid.err = is_digit ? url_ss_pkg::ERR_RANGE : url_ss_pkg::ERR_DIGIT;
          end
          st_mid.phase = url_ss_pkg::PH_DISCARD;
        end
      end
      url_ss_pkg::PH_PATH: begin
        if (is_quest) begin
          st_mid.phase = url_ss_pkg::PH_QUERY;
        end else if (is_hash) begin
          st_mid.phase = url_ss_pkg::PH_FRAG;
        end
      end
      url_ss_pkg::PH_QUERY: begin
        if (is_hash) st_mid.phase = url_ss_pkg::PH_FRAG;
      end
      default: begin
      end
    endcase

    st_post = st_mid;
    if (last_byte) begin
      if (st_mid.phase == url_ss_pkg::PH_SCHEME) begin
        if (st_mid.held != 2'd0) begin
          st_post.sm = url_ss_pkg::sm_step(st_post.sm, url_ss_pkg::CH_COLON);
        end
        if (st_mid.held == 2'd2) begin
          st_post.sm = url_ss_pkg::sm_step(st_post.sm, url_ss_pkg::CH_SLASH);
        end
        st_post.held = 2'd0;
        if (st_mid.err == url_ss_pkg::ERR_NONE) st_post.err = url_ss_pkg::ERR_NO_SEP;
      end else if (st_mid.phase == url_ss_pkg::PH_HOST && !st_mid.host_started &&
                   st_mid.err == url_ss_pkg::ERR_NONE) begin
        st_post.err = url_ss_pkg::ERR_HOST;
      end
    end

    st_next = last_byte ? url_ss_pkg::STATE_RST : st_post;
  end

  // result list
  always_comb begin
    logic taken;
    taken = 1'b0;
    lst   = '0;
    unique case (st.phase)
      url_ss_pkg::PH_SCHEME: begin
        if (st.held == 2'd2) begin
          if (is_slash) begin
            lst   = url_ss_pkg::push_res(lst, url_ss_pkg::CH_COLON, url_ss_pkg::SEG_SEP);
            lst   = url_ss_pkg::push_res(lst, url_ss_pkg::CH_SLASH, url_ss_pkg::SEG_SEP);
            lst   = url_ss_pkg::push_res(lst, url_ss_pkg::CH_SLASH, url_ss_pkg::SEG_SEP);
            taken = 1'b1;
          end else begin
            lst = url_ss_pkg::push_res(lst, url_ss_pkg::CH_COLON, url_ss_pkg::SEG_SCHEME);
            lst = url_ss_pkg::push_res(lst, url_ss_pkg::CH_SLASH, url_ss_pkg::SEG_SCHEME);
          end
        end else if (st.held == 2'd1) begin
          if (is_slash) begin
            taken = 1'b1;
          end else begin
            lst = url_ss_pkg::push_res(lst, url_ss_pkg::CH_COLON, url_ss_pkg::SEG_SCHEME);
          end
        end
        if (!taken && !is_colon) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_SCHEME);
        end
      end
      url_ss_pkg::PH_HOST: begin
        priority if ((is_colon || is_slash || is_quest || is_hash) && !st.host_started) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_DISCARD);
        end else if (is_colon) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_COLON);
        end else if (is_slash) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_PATH);
        end else if (is_quest) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_QMARK);
        end else if (is_hash) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_HASH);
        end else begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_HOST);
        end
      end
      url_ss_pkg::PH_PORT: begin
        priority if (is_slash) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_PATH);
        end else if (is_quest) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_QMARK);
        end else if (is_hash) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_HASH);
        end else if (is_digit && !port_bad) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_PORT);
        end else begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_DISCARD);
        end
      end
      url_ss_pkg::PH_PATH: begin
        priority if (is_quest) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_QMARK);
        end else if (is_hash) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_HASH);
        end else begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_PATH);
        end
      end
      url_ss_pkg::PH_QUERY: begin
        if (is_hash) begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_HASH);
        end else begin
          lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_QUERY);
        end
      end
      url_ss_pkg::PH_FRAG: begin
        lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_FRAG);
      end
      default: begin
        lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_DISCARD);
      end
    endcase

    if (last_byte) begin
      if (st_mid.phase == url_ss_pkg::PH_SCHEME) begin
        if (st_mid.held != 2'd0) begin
          lst = url_ss_pkg::push_res(lst, url_ss_pkg::CH_COLON, url_ss_pkg::SEG_SCHEME);
        end
        if (st_mid.held == 2'd2) begin
          lst = url_ss_pkg::push_res(lst, url_ss_pkg::CH_SLASH, url_ss_pkg::SEG_SCHEME);
        end
      end
      if (lst.cnt == 2'd0) begin
        lst = url_ss_pkg::push_res(lst, data_byte, url_ss_pkg::SEG_DISCARD);
      end
    end
  end

  // summary fields on the final result only
  always_comb begin
    logic [15:0] port_fin;
    logic        is_final;
    port_fin = (st_post.port_acc == 16'd0 && st_post.sm == url_ss_pkg::MATCH_FULL) ?
               default_port : st_post.port_acc;
    for (int i = 0; i < url_ss_pkg::MAX_RES; i++) begin
      res[i].data     = lst.data[i];
      res[i].segment  = lst.seg[i];
      res[i].run_last = lst.cnt == 2'(i + 1);
      is_final        = last_byte && lst.cnt == 2'(i + 1);
      res[i].done_res = is_final;
      res[i].error_code     = is_final ? st_post.err : url_ss_pkg::ERR_NONE;
      res[i].port_value     = (is_final && st_post.err == url_ss_pkg::ERR_NONE) ?
                              port_fin : 16'd0;
      res[i].path_defaulted = is_final && st_post.err == url_ss_pkg::ERR_NONE &&
                              !st_post.path_seen;
    end
  end

  assign res_cnt = lst.cnt;

endmodule

/* design/url_ss_queue.sv */
// url_ss_queue: small result queue, takes up to three results per request, one out per cycle while pop is high
// depends on url_ss_pkg
module url_ss_queue (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          push,
  input  logic [1:0]                                    push_cnt,
  input  url_ss_pkg::result_t [url_ss_pkg::MAX_RES-1:0] push_res,
  input  logic                                          pop,
  output url_ss_pkg::result_t                           head,
  output logic                                          head_valid,
  output logic                                          room
);

  url_ss_pkg::result_t entries [url_ss_pkg::QDEPTH];

  logic [url_ss_pkg::QPTR_W-1:0] wr_ptr;
  logic [url_ss_pkg::QPTR_W-1:0] rd_ptr;
  logic [url_ss_pkg::QCNT_W-1:0] count;
  logic [url_ss_pkg::QCNT_W-1:0] count_next;
  logic [url_ss_pkg::QCNT_W-1:0] add_cnt;

  assign add_cnt    = push ? url_ss_pkg::QCNT_W'(push_cnt) : '0;
  assign count_next = count + add_cnt - url_ss_pkg::QCNT_W'(pop);
  assign head       = entries[rd_ptr];
  assign head_valid = count != '0;
  assign room       = count <= url_ss_pkg::QCNT_W'(url_ss_pkg::QDEPTH - url_ss_pkg::MAX_RES);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + url_ss_pkg::QPTR_W'(add_cnt);
      rd_ptr <= rd_ptr + url_ss_pkg::QPTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < url_ss_pkg::MAX_RES; i++) begin
      if (push && 2'(i) < push_cnt) begin
        entries[wr_ptr + url_ss_pkg::QPTR_W'(i)] <= push_res[i];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= url_ss_pkg::QCNT_W'(url_ss_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - url_ss_pkg::QCNT_W'(1))
    else $error("queue count wrong after pop");

endmodule

/* design/url_stream_splitter_top.sv */
// url_stream_splitter_top: url byte classifier with port parse and end-of-url summary
// depends on url_ss_pkg, url_ss_classify, url_ss_queue
//
// usage:
//   slave channel takes one url byte per request; s_tlast marks the final byte
//   master channel gives one result per request: the byte with its segment tag,
//   run_last in m_tuser marks the last result of an input byte, m_tlast marks
//   the final result of the url, which alone carries error code, port and
//   path-defaulted flag
//   cfg_we/cfg_wdata write the default port (reset 80); users must do so while the block is idle (not enforced)
// timing and throughput:
//   a byte's parse step runs in the cycle it is accepted; its results are
//   registered into the result queue and reach the master side from its head
//   one byte per cycle when each byte yields one result and m_tready stays high;
//   a confirmed "://" yields three results, and then the four-entry result queue
//   sets the pace (s_tready is high while at least three queue entries are free)
// reset:
//   rst clears the parse state and the queue and reloads the default port;
//   after each final byte the parse state returns to its reset value
// stall:
//   while m_tready is low results wait in the queue and s_tready drops once
//   fewer than three entries are free
module url_stream_splitter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, [26:11] port_value,
                                 // [27] path_defaulted, [31:28] zero
  output logic [4:0]  m_tuser,   // [3:0] segment, [4] run_last
  output logic        m_tlast,   // done_res
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  url_ss_pkg::parse_state_t                      st;
  url_ss_pkg::parse_state_t                      st_next;
  url_ss_pkg::result_t [url_ss_pkg::MAX_RES-1:0] res;
  url_ss_pkg::result_t                           head;
  logic [1:0]                                    res_cnt;
  logic [15:0]                                   default_port;
  logic                                          accept;
  logic                                          pop;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= url_ss_pkg::STATE_RST;
      default_port <= url_ss_pkg::DEFAULT_PORT_RST;
    end else begin
      if (accept) st <= st_next;
      if (cfg_we) default_port <= cfg_wdata;
    end
  end

  url_ss_classify u_classify (
    .st           (st),
    .data_byte    (s_tdata),
    .last_byte    (s_tlast),
    .default_port (default_port),
    .st_next      (st_next),
    .res          (res),
    .res_cnt      (res_cnt)
  );

  url_ss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_cnt   (res_cnt),
    .push_res   (res),
    .pop        (pop),
    .head       (head),
    .head_valid (m_tvalid),
    .room       (s_tready)
  );

  assign m_tdata = {4'd0, head.path_defaulted, head.port_value, head.error_code, head.data};
  assign m_tuser = {head.run_last, head.segment};
  assign m_tlast = head.done_res;

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[4])
    else $error("final result not marked as last of its byte");

  a_summary_final_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[27:8] == 20'd0)
    else $error("summary fields set on a non-final result");

  a_err_no_port: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10:8] != url_ss_pkg::ERR_NONE |-> m_tdata[27:11] == 17'd0)
    else $error("port or path flag reported with an error");

endmodule
